// ----- hw/rtl/cttr_pkg.sv -----
package cttr_pkg;

  localparam int T_W   = 21;
  localparam int CH_W  = 16;
  localparam int QFRAC = 28;

  typedef logic signed [31:0] q_t;
  typedef logic signed [33:0] qw_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  localparam longint DEC_SCALE = 100000000;

  localparam int T_LOW        = 1500;
  localparam int T_HIGH       = 40000;
  localparam int T_SPLIT_HIGH = 4000;
  localparam int T_SPLIT_LOW  = 2222;
  localparam int OUT_ONE      = 32768;

  // decimal constant in units of 1e-8 to q4.28, rounded half away from zero
  function automatic q_t to_q(input longint dec);
    longint unsigned m;
    longint unsigned q;
    m = (dec < 0) ? longint'(-dec) : longint'(dec);
    q = ((m << QFRAC) + DEC_SCALE / 2) / DEC_SCALE;
    return (dec < 0) ? q_t'(32'(0) - q[31:0]) : q_t'(q[31:0]);
  endfunction

  localparam q_t Q_ONE   = to_q(100000000);
  localparam q_t Q_FLOOR = to_q(10000);

  // polynomial coefficients, highest power first
  localparam q_t CX_LOW [4]  = '{to_q(-26612390), to_q(-23435890), to_q(87769560),
                                 to_q(17991000)};
  localparam q_t CX_HIGH [4] = '{to_q(-302584690), to_q(210703790), to_q(22263470),
                                 to_q(24039000)};
  localparam q_t CY_LOW [4]  = '{to_q(-110638140), to_q(-134811020), to_q(218555832),
                                 to_q(-20219683)};
  localparam q_t CY_MID [4]  = '{to_q(-95494760), to_q(-137418593), to_q(209137015),
                                 to_q(-16748867)};
  localparam q_t CY_HIGH [4] = '{to_q(308175800), to_q(-587338670), to_q(375112997),
                                 to_q(-37001483)};

  // rows: weight on X, constant term (Y = 1), weight on Z
  localparam q_t CMAT [3][3] = '{
    '{to_q(324045420), to_q(-153713850), to_q(-49853140)},
    '{to_q(-96926600), to_q(187601080), to_q(4155600)},
    '{to_q(5564340), to_q(-20402590), to_q(105722520)}
  };

  function automatic qw_t ext34(input q_t v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic q_t sat34(input qw_t v);
    if (v > ext34(Q_MAX)) return Q_MAX;
    else if (v < ext34(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag(input q_t v);
    logic [32:0] e;
    e = {v[31], v};
    return v[31] ? 32'(33'(0) - e) : v[31:0];
  endfunction

  // sign and magnitude back to q4.28, magnitude clamped to 2^31 first
  function automatic q_t signed_of(input logic neg, input logic [35:0] m);
    logic [31:0] mc;
    mc = (m > 36'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
    if (neg) return q_t'(32'(0) - mc);
    return mc[31] ? Q_MAX : q_t'(mc);
  endfunction

endpackage

// ----- hw/rtl/cttr_if.sv -----
interface cttr_temp_if;
  logic                      valid;
  logic                      ready;
  logic [cttr_pkg::T_W-1:0]  temperature_kelvin;

  modport source (output valid, output temperature_kelvin, input ready);
  modport sink (input valid, input temperature_kelvin, output ready);
endinterface

interface cttr_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [cttr_pkg::CH_W-1:0] red;
  logic [cttr_pkg::CH_W-1:0] green;
  logic [cttr_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/color_temperature_to_rgb.sv -----
// Color temperature to normalized linear sRGB. Each transfer on kelvin carries
// a temperature, clamped to 1500..40000 K; each transfer on rgb carries red,
// green and blue in unsigned q1.15 (32768 is 1.0), scaled so the largest
// channel is 1.0. The block takes one temperature every clock and is fully
// pipelined. The depth comes from the clamp, divisor, peak and result registers,
// the pipelined dividers (28 stages for 1000/T, 33 for the two chromaticity
// quotients, 16 for the final normalization) and the two-stage multiply-add
// units for the chromaticity cubics and the color matrix. When rgb is not
// ready and the output register is full, every stage holds; kelvin.ready
// follows from that, and is low while reset is asserted.
module color_temperature_to_rgb (
  input  logic            clk,
  input  logic            rst,
  cttr_temp_if.sink       kelvin,
  cttr_rgb_if.source      rgb
);

  localparam logic [37:0] INV_NUM = 38'd1000 << cttr_pkg::QFRAC;

  // x-polynomial coefficient, lower set below the high split
  function automatic cttr_pkg::q_t cx_coef(input logic below_hi, input int k);
    return below_hi ? cttr_pkg::CX_LOW[k] : cttr_pkg::CX_HIGH[k];
  endfunction

  // y-polynomial coefficient; sel[0] below low split, sel[1] below high split
  function automatic cttr_pkg::q_t cy_coef(input logic [1:0] sel, input int k);
    if (sel[0]) return cttr_pkg::CY_LOW[k];
    else if (sel[1]) return cttr_pkg::CY_MID[k];
    return cttr_pkg::CY_HIGH[k];
  endfunction

  logic advance;
  logic out_v;

  // whole pipeline moves unless the result register is stuck
  assign advance      = !out_v || rgb.ready;
  assign kelvin.ready = advance && !rst;

  // ---- clamp
  logic [cttr_pkg::T_W-1:0] t_raw;
  logic [15:0]              t_clamp;
  logic [15:0]              s0_t;
  logic                     s0_v;
  logic [1:0]               s0_sel;

  assign t_raw = kelvin.temperature_kelvin;

  always_comb begin
    if (t_raw < cttr_pkg::T_W'(cttr_pkg::T_LOW)) begin
      t_clamp = 16'(cttr_pkg::T_LOW);
    end else if (t_raw > cttr_pkg::T_W'(cttr_pkg::T_HIGH)) begin
      t_clamp = 16'(cttr_pkg::T_HIGH);
    end else begin
      t_clamp = t_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (advance) begin
      s0_v <= kelvin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_t <= t_clamp;
    end
  end

  // exactly 4000 takes the upper set, exactly 2222 the middle one
  assign s0_sel = {s0_t < 16'(cttr_pkg::T_SPLIT_HIGH), s0_t < 16'(cttr_pkg::T_SPLIT_LOW)};

  // ---- 1000/T in q4.28, rounded
  logic        inv_v;
  logic [27:0] inv_q;
  logic        inv_ovf;
  logic [1:0]  inv_sel;
  cttr_pkg::q_t inv;

  cttr_div #(.NW(38), .DW(16), .QW(28), .SW(2)) u_div_inv (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s0_v),
    .num       (INV_NUM + 38'(s0_t >> 1)),
    .den       (s0_t),
    .in_sb     (s0_sel),
    .out_valid (inv_v),
    .quot      (inv_q),
    .out_ovf   (inv_ovf),
    .out_sb    (inv_sel)
  );

  assign inv = inv_ovf ? cttr_pkg::Q_MAX : cttr_pkg::q_t'(32'(inv_q));

  // ---- x = cubic in 1000/T, horner form; side data is {sel, 1000/T}
  logic         x1_v, x2_v, x3_v;
  cttr_pkg::q_t x1_y, x2_y, x3_y;
  logic [33:0]  x1_sb, x2_sb;
  logic [1:0]   x3_sb;

  cttr_mac #(.SW(34)) u_mac_x1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(inv_v),
    .a(cx_coef(inv_sel[1], 0)), .b(inv), .c(cx_coef(inv_sel[1], 1)),
    .in_sb({inv_sel, inv}), .out_valid(x1_v), .y(x1_y), .out_sb(x1_sb)
  );

  cttr_mac #(.SW(34)) u_mac_x2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(x1_v),
    .a(x1_y), .b(x1_sb[31:0]), .c(cx_coef(x1_sb[33], 2)),
    .in_sb(x1_sb), .out_valid(x2_v), .y(x2_y), .out_sb(x2_sb)
  );

  cttr_mac #(.SW(2)) u_mac_x3 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(x2_v),
    .a(x2_y), .b(x2_sb[31:0]), .c(cx_coef(x2_sb[33], 3)),
    .in_sb(x2_sb[33:32]), .out_valid(x3_v), .y(x3_y), .out_sb(x3_sb)
  );

  // ---- y = cubic in x; side data is {sel, x}
  logic         y1_v, y2_v, y3_v;
  cttr_pkg::q_t y1_y, y2_y, y3_y;
  logic [33:0]  y1_sb, y2_sb;
  logic [31:0]  y3_sb;

  cttr_mac #(.SW(34)) u_mac_y1 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(x3_v),
    .a(cy_coef(x3_sb, 0)), .b(x3_y), .c(cy_coef(x3_sb, 1)),
    .in_sb({x3_sb, x3_y}), .out_valid(y1_v), .y(y1_y), .out_sb(y1_sb)
  );

  cttr_mac #(.SW(34)) u_mac_y2 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(y1_v),
    .a(y1_y), .b(y1_sb[31:0]), .c(cy_coef(y1_sb[33:32], 2)),
    .in_sb(y1_sb), .out_valid(y2_v), .y(y2_y), .out_sb(y2_sb)
  );

  cttr_mac #(.SW(32)) u_mac_y3 (
    .clk(clk), .rst(rst), .en(advance), .in_valid(y2_v),
    .a(y2_y), .b(y2_sb[31:0]), .c(cy_coef(y2_sb[33:32], 3)),
    .in_sb(y2_sb[31:0]), .out_valid(y3_v), .y(y3_y), .out_sb(y3_sb)
  );

  // ---- floored divisor and z numerator 1 - x - y
  cttr_pkg::q_t ys_c, zn1, zn_c;
  cttr_pkg::q_t p_x, p_ys, p_zn;
  logic         p_v;

  assign ys_c = (y3_y < cttr_pkg::Q_FLOOR) ? cttr_pkg::Q_FLOOR : y3_y;
  assign zn1  = cttr_pkg::sat34(cttr_pkg::ext34(cttr_pkg::Q_ONE) - cttr_pkg::ext34(y3_sb));
  assign zn_c = cttr_pkg::sat34(cttr_pkg::ext34(zn1) - cttr_pkg::ext34(y3_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (advance) begin
      p_v <= y3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_x  <= y3_sb;
      p_ys <= ys_c;
      p_zn <= zn_c;
    end
  end

  // ---- X = x / y', Z = (1 - x - y) / y', magnitudes with sign carried aside
  logic         tx_v, tz_v, txz_v;
  logic [32:0]  tx_q, tz_q;
  logic         tx_ovf, tz_ovf;
  logic         tx_neg, tz_neg;
  cttr_pkg::q_t tx, tz;

  cttr_div #(.NW(60), .DW(32), .QW(33), .SW(1)) u_div_tx (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (p_v),
    .num       ((60'(cttr_pkg::mag(p_x)) << cttr_pkg::QFRAC) + 60'(p_ys[31:1])),
    .den       (p_ys),
    .in_sb     (p_x[31]),
    .out_valid (tx_v),
    .quot      (tx_q),
    .out_ovf   (tx_ovf),
    .out_sb    (tx_neg)
  );

  cttr_div #(.NW(60), .DW(32), .QW(33), .SW(1)) u_div_tz (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (p_v),
    .num       ((60'(cttr_pkg::mag(p_zn)) << cttr_pkg::QFRAC) + 60'(p_ys[31:1])),
    .den       (p_ys),
    .in_sb     (p_zn[31]),
    .out_valid (tz_v),
    .quot      (tz_q),
    .out_ovf   (tz_ovf),
    .out_sb    (tz_neg)
  );

  // an overflowing quotient is taken as all ones; any magnitude past 2^31 then saturates
  assign tx    = cttr_pkg::signed_of(tx_neg, tx_ovf ? 36'h0_FFFF_FFFF : 36'(tx_q));
  assign tz    = cttr_pkg::signed_of(tz_neg, tz_ovf ? 36'h0_FFFF_FFFF : 36'(tz_q));
  assign txz_v = tx_v & tz_v;

  // ---- color matrix, one lane per channel
  logic [2:0]   m1_v, m2_v;
  cttr_pkg::q_t m1_y [3];
  cttr_pkg::q_t m2_y [3];
  logic [31:0]  m1_sb [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cttr_mac #(.SW(32)) u_mac_m1 (
      .clk(clk), .rst(rst), .en(advance), .in_valid(txz_v),
      .a(cttr_pkg::CMAT[i][0]), .b(tx), .c(cttr_pkg::CMAT[i][1]),
      .in_sb(tz), .out_valid(m1_v[i]), .y(m1_y[i]), .out_sb(m1_sb[i])
    );

    cttr_mac #(.SW(1)) u_mac_m2 (
      .clk(clk), .rst(rst), .en(advance), .in_valid(m1_v[i]),
      .a(cttr_pkg::CMAT[i][2]), .b(m1_sb[i]), .c(m1_y[i]),
      .in_sb(1'b0), .out_valid(m2_v[i]), .y(m2_y[i]), .out_sb()
    );
  end

  // ---- negatives to zero, peak floored at 1e-4
  logic [30:0] ch_c [3];
  logic [30:0] peak_c;
  logic [30:0] pk_ch [3];
  logic [30:0] pk_peak;
  logic        pk_v;

  always_comb begin
    peak_c = cttr_pkg::Q_FLOOR[30:0];
    for (int i = 0; i < 3; i++) begin
      ch_c[i] = m2_y[i][31] ? 31'd0 : m2_y[i][30:0];
      if (ch_c[i] > peak_c) begin
        peak_c = ch_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_v <= 1'b0;
    end else if (advance) begin
      pk_v <= &m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pk_ch   <= ch_c;
      pk_peak <= peak_c;
    end
  end

  // ---- normalize: round(ch * 2^15 / peak), half up
  logic [2:0]  nd_v;
  logic [15:0] nd_q [3];
  logic [2:0]  nd_ovf;
  logic [15:0] nd_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_norm
    cttr_div #(.NW(47), .DW(31), .QW(16), .SW(1)) u_div_norm (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (pk_v),
      .num       ((47'(pk_ch[i]) << 15) + 47'(pk_peak >> 1)),
      .den       (pk_peak),
      .in_sb     (1'b0),
      .out_valid (nd_v[i]),
      .quot      (nd_q[i]),
      .out_ovf   (nd_ovf[i]),
      .out_sb    ()
    );

    assign nd_r[i] = (nd_ovf[i] || nd_q[i] > 16'(cttr_pkg::OUT_ONE)) ?
                     16'(cttr_pkg::OUT_ONE) : nd_q[i];
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= &nd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rgb.red   <= nd_r[0];
      rgb.green <= nd_r[1];
      rgb.blue  <= nd_r[2];
    end
  end

  assign rgb.valid = out_v;

endmodule

// ----- hw/rtl/cttr_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module cttr_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_sb,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic          out_ovf,
  output logic [SW-1:0] out_sb
);

  localparam int WW = DW + QW;

  logic [WW-1:0] w_r   [QW];
  logic [DW-1:0] d_r   [QW-1];
  logic [SW-1:0] sb_r  [QW];
  logic [QW-1:0] v_r;
  logic [QW-1:0] ovf_r;

  logic [NW-1:0] head;
  logic          first_ovf;
  logic [WW-1:0] w_cur [QW];
  logic [DW-1:0] d_cur [QW];
  logic [DW:0]   top   [QW];
  logic [DW:0]   diff  [QW];
  logic [QW-1:0] ge;
  logic [WW-1:0] w_nxt [QW];

  // quotient fits only if the leading part is below the divisor
  assign head      = num >> QW;
  assign first_ovf = head >= NW'(den);

  always_comb begin
    w_cur[0] = {DW'(head), num[QW-1:0]};
    d_cur[0] = den;
    for (int k = 1; k < QW; k++) begin
      w_cur[k] = w_r[k-1];
      d_cur[k] = d_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      top[k]   = w_cur[k][WW-1:QW-1];
      ge[k]    = top[k] >= {1'b0, d_cur[k]};
      diff[k]  = top[k] - {1'b0, d_cur[k]};
      w_nxt[k] = {ge[k] ? diff[k][DW-1:0] : top[k][DW-1:0], w_cur[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        w_r[k] <= w_nxt[k];
      end
      for (int k = 0; k < QW - 1; k++) begin
        d_r[k] <= d_cur[k];
      end
      sb_r[0] <= in_sb;
      for (int k = 1; k < QW; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      ovf_r <= {ovf_r[QW-2:0], first_ovf};
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot      = w_r[QW-1][QW-1:0];
  assign out_ovf   = ovf_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule

// ----- hw/rtl/cttr_mac.sv -----
// y = sat(round(a * b) + c) in q4.28, two register stages
module cttr_mac #(
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  cttr_pkg::q_t    a,
  input  cttr_pkg::q_t    b,
  input  cttr_pkg::q_t    c,
  input  logic [SW-1:0]   in_sb,
  output logic            out_valid,
  output cttr_pkg::q_t    y,
  output logic [SW-1:0]   out_sb
);

  logic [63:0]   prod;
  logic          neg;
  cttr_pkg::q_t  c_r;
  logic [SW-1:0] sb_a;
  logic          v_a;

  logic [63:0]   rnd;
  cttr_pkg::q_t  prod_q;
  cttr_pkg::qw_t sum;

  // stage a: magnitude product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= cttr_pkg::mag(a) * cttr_pkg::mag(b);
      neg  <= a[31] ^ b[31];
      c_r  <= c;
      sb_a <= in_sb;
    end
  end

  // stage b: round half away from zero, saturate, add
  assign rnd    = prod + (64'd1 << (cttr_pkg::QFRAC - 1));
  assign prod_q = cttr_pkg::signed_of(neg, rnd[cttr_pkg::QFRAC+35:cttr_pkg::QFRAC]);
  assign sum    = cttr_pkg::ext34(prod_q) + cttr_pkg::ext34(c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      y      <= cttr_pkg::sat34(sum);
      out_sb <= sb_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a       <= in_valid;
      out_valid <= v_a;
    end
  end

endmodule

// ----- dv/color_temperature_to_rgb_tb.sv -----
`timescale 1ns / 100ps

module color_temperature_to_rgb_tb;

  typedef struct packed {
    logic [cttr_pkg::CH_W-1:0] red;
    logic [cttr_pkg::CH_W-1:0] green;
    logic [cttr_pkg::CH_W-1:0] blue;
  } rgb_t;

  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;

  // curve coefficients in units of 1e-8, highest power first
  localparam longint XK_LO [4] = '{-26612390, -23435890, 87769560, 17991000};
  localparam longint XK_HI [4] = '{-302584690, 210703790, 22263470, 24039000};
  localparam longint YK_LO [4] = '{-110638140, -134811020, 218555832, -20219683};
  localparam longint YK_MID [4] = '{-95494760, -137418593, 209137015, -16748867};
  localparam longint YK_HI [4] = '{308175800, -587338670, 375112997, -37001483};
  // srgb rows: weight on X, constant for Y = 1, weight on Z
  localparam longint SRGB_K [3][3] = '{
    '{324045420, -153713850, -49853140},
    '{-96926600, 187601080, 4155600},
    '{5564340, -20402590, 105722520}
  };

  localparam int TAIL_ITEMS  = 150;
  localparam int DRAIN_WAIT  = 150;
  localparam int LONG_HOLD   = 400;

  logic clk;
  logic rst;

  cttr_temp_if kelvin_bus ();
  cttr_rgb_if  rgb_bus ();

  color_temperature_to_rgb DUT (
    .clk    (clk),
    .rst    (rst),
    .kelvin (kelvin_bus),
    .rgb    (rgb_bus)
  );

  // ---------------------------------------------------------------------
  // fixed point helpers, q4.28 held in 64-bit signed integers
  // ---------------------------------------------------------------------
  function automatic longint q_sat(input longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint unsigned q_abs(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // sign and magnitude back to q4.28, magnitude capped at 2^31
  function automatic longint q_pack(input bit neg, input longint unsigned m);
    longint unsigned mc;
    mc = (m > 64'd2147483648) ? 64'd2147483648 : m;
    return neg ? q_sat(-longint'(mc)) : q_sat(longint'(mc));
  endfunction

  function automatic longint dec_to_q(input longint dec);
    longint unsigned m;
    m = q_abs(dec);
    return q_pack(dec < 0, ((m << 28) + 64'd50000000) / 64'd100000000);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    longint unsigned p;
    p = q_abs(a) * q_abs(b);
    p = (p + (64'd1 << 27)) >> 28;
    return q_pack((a < 0) != (b < 0), p);
  endfunction

  function automatic longint q_div(input longint n, input longint d);
    longint unsigned dm;
    dm = q_abs(d);
    if (dm == 0) return (n < 0) ? QLO : QHI;
    return q_pack((n < 0) != (d < 0), ((q_abs(n) << 28) + dm / 2) / dm);
  endfunction

  // horner form, every step rounded and saturated
  function automatic longint horner3(input longint k [4], input longint t);
    longint acc;
    acc = dec_to_q(k[0]);
    for (int i = 1; i < 4; i++) acc = q_sat(q_mul(acc, t) + dec_to_q(k[i]));
    return acc;
  endfunction

  function automatic rgb_t kelvin_to_rgb(input logic [cttr_pkg::T_W-1:0] tk);
    longint t, inv, cx, cy, cy_floor, tri_x, tri_z, peak, v;
    longint lin [3];
    longint unsigned r;
    logic [cttr_pkg::CH_W-1:0] outc [3];
    rgb_t res;
    t = tk;
    if (t < cttr_pkg::T_LOW) t = cttr_pkg::T_LOW;
    if (t > cttr_pkg::T_HIGH) t = cttr_pkg::T_HIGH;
    inv = ((64'd1000 << 28) + t / 2) / t;
    // upper x curve from 4000 K inclusive, middle y curve from 2222 K inclusive
    if (t < cttr_pkg::T_SPLIT_HIGH) cx = horner3(XK_LO, inv);
    else cx = horner3(XK_HI, inv);
    if (t < cttr_pkg::T_SPLIT_LOW) cy = horner3(YK_LO, cx);
    else if (t < cttr_pkg::T_SPLIT_HIGH) cy = horner3(YK_MID, cx);
    else cy = horner3(YK_HI, cx);
    // divisor floored, Z numerator still uses raw y
    cy_floor = (cy < dec_to_q(10000)) ? dec_to_q(10000) : cy;
    tri_x = q_div(cx, cy_floor);
    tri_z = q_div(q_sat(q_sat(dec_to_q(100000000) - cx) - cy), cy_floor);
    for (int i = 0; i < 3; i++) begin
      v = q_mul(dec_to_q(SRGB_K[i][0]), tri_x);
      v = q_sat(v + dec_to_q(SRGB_K[i][1]));
      v = q_sat(v + q_mul(dec_to_q(SRGB_K[i][2]), tri_z));
      lin[i] = (v < 0) ? 0 : v;
    end
    peak = dec_to_q(10000);
    for (int i = 0; i < 3; i++) if (lin[i] > peak) peak = lin[i];
    for (int i = 0; i < 3; i++) begin
      r = ((longint'(lin[i]) << 15) + peak / 2) / peak;
      if (r > cttr_pkg::OUT_ONE) r = cttr_pkg::OUT_ONE;
      outc[i] = r[cttr_pkg::CH_W-1:0];
    end
    res.red = outc[0];
    res.green = outc[1];
    res.blue = outc[2];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [cttr_pkg::T_W-1:0] temps_pending [$];
  rgb_t                     rgb_expected [$];
  int                       fail_count;
  int                       accepted_temps;
  logic                     temp_taken;
  int                       src_gap;
  int                       sink_gap;
  logic                     long_hold;

  initial begin
    rst = 1'b1;
    kelvin_bus.valid = 1'b0;
    kelvin_bus.temperature_kelvin = '0;
    rgb_bus.ready = 1'b0;
    fail_count = 0;
    accepted_temps = 0;
    src_gap = 0;
    sink_gap = 0;
    long_hold = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------------
  // stimulus: directed corners, then mostly in-range random temperatures
  // ---------------------------------------------------------------------
  initial begin
    int sel;
    // clamps, both branch points with their neighbors, field extremes
    temps_pending = '{0, 1, 1499, 1500, 1501, 2221, 2222, 2223, 3999, 4000, 4001,
                      6500, 39999, 40000, 40001, 2097151, 1048576, 1048575,
                      21'h0AAAAA, 21'h155555, 1000, 10000, 25000};
    for (int n = 0; n < 1900; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65)
        temps_pending = {temps_pending,
                         cttr_pkg::T_W'($urandom_range(cttr_pkg::T_LOW, cttr_pkg::T_HIGH))};
      else if (sel < 80)
        temps_pending = {temps_pending,
                         cttr_pkg::T_W'($urandom_range(cttr_pkg::T_LOW, 6000))};
      else if (sel < 88)
        temps_pending = {temps_pending,
                         cttr_pkg::T_W'($urandom_range(0, cttr_pkg::T_LOW - 1))};
      else
        temps_pending = {temps_pending, cttr_pkg::T_W'($urandom_range(0, 2097151))};
    end
  end

  // ---------------------------------------------------------------------
  // monitor: prediction on input transfer, check on result transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      temp_taken <= 1'b0;
    end else begin
      temp_taken <= kelvin_bus.valid && kelvin_bus.ready;
      if (kelvin_bus.valid && kelvin_bus.ready) begin
        rgb_expected = {rgb_expected, kelvin_to_rgb(kelvin_bus.temperature_kelvin)};
        accepted_temps++;
      end
      if (rgb_bus.valid && rgb_bus.ready) begin
        if (rgb_expected.size() == 0) begin
          $display("%0t: unexpected rgb transfer %0d %0d %0d", $time,
                   rgb_bus.red, rgb_bus.green, rgb_bus.blue);
          fail_count++;
        end else begin
          want = rgb_expected.pop_front();
          if (rgb_bus.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, rgb_bus.red);
            fail_count++;
          end
          if (rgb_bus.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green,
                     rgb_bus.green);
            fail_count++;
          end
          if (rgb_bus.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, rgb_bus.blue);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // driver: new temperature on the falling edge once the last one went
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic tail;
    if (!rst) begin
      tail = temps_pending.size() < TAIL_ITEMS;
      if (temp_taken || !kelvin_bus.valid) begin
        if (src_gap > 0) begin
          kelvin_bus.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (temps_pending.size() > 0) begin
          kelvin_bus.valid <= 1'b1;
          kelvin_bus.temperature_kelvin <= temps_pending.pop_front();
          // occasional idle burst after this transfer
          if (!tail && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 7);
        end else begin
          kelvin_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold from its own process
  always @(negedge clk) begin
    logic tail;
    if (!rst) begin
      tail = temps_pending.size() < TAIL_ITEMS;
      if (sink_gap > 0) begin
        rgb_bus.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!tail && $urandom_range(0, 9) == 0) begin
        rgb_bus.ready <= 1'b0;
        sink_gap <= $urandom_range(0, 6);
      end else begin
        rgb_bus.ready <= !long_hold;
      end
    end
  end

  // long back-pressure: pipeline fills and kelvin.ready must drop
  initial begin
    wait (accepted_temps >= 300);
    @(negedge clk);
    long_hold = 1'b1;
    for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
    long_hold = 1'b0;
  end

  // ---------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------
  initial begin
    wait (!rst);
    wait (temps_pending.size() == 0);
    @(posedge clk);
    while (kelvin_bus.valid || rgb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("color_temperature_to_rgb_tb: PASS");
    else $display("color_temperature_to_rgb_tb: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("%0t: timeout, %0d results still expected", $time, rgb_expected.size());
    $display("color_temperature_to_rgb_tb: FAIL");
    $finish;
  end

endmodule
